// ===== rtl/core/lsb_stego_extractor_assert.svh =====
// ----------------------------------------------------------------------------
// lsb_stego_extractor assertion macros
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef LSB_STEGO_EXTRACTOR_ASSERT_SVH
`define LSB_STEGO_EXTRACTOR_ASSERT_SVH

// same-cycle implication
`define LSBX_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lsbx assertion failed");

// next-cycle implication
`define LSBX_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lsbx assertion failed");

`endif

// ===== rtl/core/lsbx_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbx_pkg
// Shared types and constants of the LSB message extractor.
// ----------------------------------------------------------------------------
package lsbx_pkg;

   localparam logic [15:0] DELIM_RESET = 16'h2424;

   localparam logic [1:0] STATUS_BYTE      = 2'd0;
   localparam logic [1:0] STATUS_DELIM     = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   localparam int FIFO_DEPTH = 4;

   typedef struct packed {
      logic [7:0] chan_blue;
      logic [7:0] chan_green;
      logic [7:0] chan_red;
      logic       end_of_image;
   } req_type;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic [3:0] bits_valid;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   // what one lane found at its bit position
   typedef struct packed {
      logic       release_byte;
      logic       match;
      logic [7:0] byte_val;
      logic [2:0] left;
   } lane_res_type;

   typedef struct packed {
      logic room2;
      logic not_empty;
   } fifo_stat_type;

endpackage

// ===== rtl/core/lsb_stego_extractor.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_extractor
// Pulls a delimited message out of the pixel LSBs of a three-channel image.
// ----------------------------------------------------------------------------
// One pixel is taken every clock unless req_stall is high: three lanes test the
// blue, green and red bit positions side by side and a merge stage turns them
// into results, so a pixel's work finishes in the cycle it is accepted. Results
// leave a four-entry queue one per clock unless rsp_stall is high; a pixel is
// taken while the queue has room for two results, so req_stall rises only when
// the consumer holds rsp_stall or a run of pixels yields two results each. A
// pixel's results are registered in the queue. The user must write the delimiter
// register (csr_we / csr_wdata) only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module lsb_stego_extractor
   import lsbx_pkg::*;
#(
   parameter int DELIM_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int HIST_BITS = DELIM_BITS + 8;
   localparam int FILL_W    = $clog2(HIST_BITS + 3);

   logic [15:0]          delim_ff;
   logic [HIST_BITS-1:0] hist_ff, hist_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic                 done_ff, done_in;

   logic                 req_fire;
   logic [2:0]           new_bits;
   logic [DELIM_BITS-1:0] pattern;
   logic [HIST_BITS+2:0] ext;
   logic [FILL_W-1:0]    fill_p3;
   lane_res_type [2:0]   lanes;
   logic                 match_any;
   logic [1:0]           push_cnt;
   rsp_type              push0, push1;
   fifo_stat_type        fstat;

   assign req_fire = req_valid && !req_stall;
   assign new_bits = {req_data.chan_blue[0], req_data.chan_green[0], req_data.chan_red[0]};
   assign pattern  = DELIM_BITS'(delim_ff);

   for (genvar g = 0; g < 3; g++) begin : g_lane
      lsbx_lane #(
         .LANE       (g),
         .DELIM_BITS (DELIM_BITS)
      ) u_lane (
         .hist     (hist_ff),
         .fill     (fill_ff),
         .new_bits (new_bits),
         .pattern  (pattern),
         .res      (lanes[g])
      );
   end

   lsbx_merge u_merge (
      .fire      (req_fire),
      .done      (done_ff),
      .eoi       (req_data.end_of_image),
      .lanes     (lanes),
      .match_any (match_any),
      .push_cnt  (push_cnt),
      .push0     (push0),
      .push1     (push1)
   );

   lsbx_rsp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_cnt (push_cnt),
      .push0    (push0),
      .push1    (push1),
      .pop      (rsp_valid && !rsp_stall),
      .head     (rsp_data),
      .stat     (fstat)
   );

   assign req_stall = !fstat.room2;
   assign rsp_valid = fstat.not_empty;

   // stream state after all three bits, used when no delimiter hit
   assign ext     = {hist_ff, new_bits};
   assign fill_p3 = fill_ff + FILL_W'(3);

   always_comb begin
      hist_in = hist_ff;
      fill_in = fill_ff;
      done_in = done_ff;
      if (req_fire) begin
         if (req_data.end_of_image) begin
            hist_in = '0;
            fill_in = '0;
            done_in = 1'b0;
         end else if (!done_ff) begin
            if (match_any) begin
               done_in = 1'b1;
            end else begin
               hist_in = ext[HIST_BITS-1:0];
               fill_in = (fill_p3 >= FILL_W'(HIST_BITS)) ? fill_p3 - FILL_W'(8) : fill_p3;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIM_RESET;
         hist_ff  <= '0;
         fill_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            delim_ff <= csr_wdata;
         end
         hist_ff <= hist_in;
         fill_ff <= fill_in;
         done_ff <= done_in;
      end
   end

endmodule

// ===== rtl/core/lsbx_lane.sv =====
// ----------------------------------------------------------------------------
// lsbx_lane
// One bit position of the pixel: byte release and delimiter compare.
// ----------------------------------------------------------------------------
module lsbx_lane
   import lsbx_pkg::*;
#(
   parameter int LANE       = 0,
   parameter int DELIM_BITS = 16
) (
   input  logic [DELIM_BITS+7:0]             hist,
   input  logic [$clog2(DELIM_BITS+11)-1:0]  fill,
   input  logic [2:0]                        new_bits,
   input  logic [DELIM_BITS-1:0]             pattern,
   output lane_res_type                      res
);

   localparam int HIST_BITS = DELIM_BITS + 8;
   localparam int FILL_W    = $clog2(HIST_BITS + 3);
   localparam int SHIFT     = 2 - LANE;

   logic [HIST_BITS+2:0] ext;
   logic [HIST_BITS-1:0] hist_c;
   logic [FILL_W-1:0]    fill_raw;
   logic [FILL_W-1:0]    fill_c;

   // first pixel bit sits in new_bits[2]
   assign ext      = {hist, new_bits};
   assign hist_c   = ext[HIST_BITS-1+SHIFT:SHIFT];
   assign fill_raw = fill + FILL_W'(LANE + 1);
   assign fill_c   = (fill_raw >= FILL_W'(HIST_BITS)) ? fill_raw - FILL_W'(8) : fill_raw;

   always_comb begin
      res.release_byte = (fill_raw == FILL_W'(HIST_BITS));
      res.match        = (fill_c >= FILL_W'(DELIM_BITS)) &&
                         (hist_c[DELIM_BITS-1:0] == pattern);
      res.byte_val     = hist_c[DELIM_BITS+7:DELIM_BITS];
      res.left         = 3'(fill_c - FILL_W'(DELIM_BITS));
   end

endmodule

// ===== rtl/core/lsbx_merge.sv =====
// ----------------------------------------------------------------------------
// lsbx_merge
// Combines the three lanes into zero, one or two results for the transaction.
// ----------------------------------------------------------------------------
module lsbx_merge
   import lsbx_pkg::*;
(
   input  logic               fire,
   input  logic               done,
   input  logic               eoi,
   input  lane_res_type [2:0] lanes,
   output logic               match_any,
   output logic [1:0]         push_cnt,
   output rsp_type            push0,
   output rsp_type            push1
);

   logic       active;
   logic       byte_hit;
   logic [7:0] byte_v;
   logic       end_hit;
   logic [2:0] left_v;
   logic [7:0] rest_v;
   logic       second_hit;
   rsp_type    byte_rsp;
   rsp_type    second_rsp;

   // lanes after the first match see no bits
   always_comb begin
      active   = !done;
      byte_hit = 1'b0;
      byte_v   = '0;
      end_hit  = 1'b0;
      left_v   = '0;
      rest_v   = '0;
      for (int c = 0; c < 3; c++) begin
         if (active) begin
            if (lanes[c].release_byte) begin
               byte_hit = 1'b1;
               byte_v   = lanes[c].byte_val;
            end
            if (lanes[c].match) begin
               end_hit = 1'b1;
               left_v  = lanes[c].left;
               rest_v  = lanes[c].byte_val;
               active  = 1'b0;
            end
         end
      end
   end

   always_comb begin
      byte_rsp.msg_byte   = byte_v;
      byte_rsp.bits_valid = 4'd8;
      byte_rsp.status     = STATUS_BYTE;
      byte_rsp.last       = 1'b0;

      second_rsp.last = 1'b1;
      if (end_hit) begin
         second_rsp.status     = STATUS_DELIM;
         second_rsp.bits_valid = {1'b0, left_v};
         second_rsp.msg_byte   = (left_v == 3'd0) ? 8'd0
                                 : 8'(rest_v << (4'd8 - {1'b0, left_v}));
      end else begin
         second_rsp.status     = STATUS_NOT_FOUND;
         second_rsp.bits_valid = 4'd0;
         second_rsp.msg_byte   = 8'd0;
      end
   end

   assign second_hit = end_hit || (eoi && !done);
   assign match_any  = end_hit;

   always_comb begin
      push0    = byte_hit ? byte_rsp : second_rsp;
      push1    = second_rsp;
      push_cnt = '0;
      if (fire) begin
         push_cnt = 2'({1'b0, byte_hit} + {1'b0, second_hit});
      end
   end

endmodule

// ===== rtl/core/lsbx_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// lsbx_rsp_fifo
// Four-entry result queue, up to two writes and one read a cycle.
// ----------------------------------------------------------------------------
module lsbx_rsp_fifo
   import lsbx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [1:0]    push_cnt,
   input  rsp_type       push0,
   input  rsp_type       push1,
   input  logic          pop,
   output rsp_type       head,
   output fifo_stat_type stat
);

   `include "lsb_stego_extractor_assert.svh"

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   rsp_type          mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PTR_W-1:0] wr_ptr_p1;

   assign wr_ptr_p1 = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign cnt_in    = cnt_ff + CNT_W'(push_cnt) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_p1] <= push1;
      end
   end

   assign head           = mem_ff[rd_ptr_ff];
   assign stat.not_empty = (cnt_ff != '0);
   assign stat.room2     = (cnt_ff <= CNT_W'(FIFO_DEPTH - 2));

   `LSBX_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_ff <= CNT_W'(FIFO_DEPTH))
   `LSBX_ASSERT_SAME(a_push_room, push_cnt != 2'd0, cnt_ff <= CNT_W'(FIFO_DEPTH - 2))
   `LSBX_ASSERT_NEXT(a_cnt_grow, push_cnt != 2'd0 && !pop, cnt_ff == $past(cnt_ff) + CNT_W'($past(push_cnt)))

endmodule

// ===== sim/lsb_stego_extractor_test.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_extractor_test
// Self-checking bench for the LSB message extractor. Pixels are built from
// bit streams carrying a message and a delimiter, with noise, cut-short and
// broken-delimiter images mixed in. Each accepted pixel runs through a local
// model of the extractor and each returned transaction is checked against
// the oldest prediction. The delimiter register is changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsb_stego_extractor_test
   import lsbx_pkg::*;
();

   localparam int DELIM_BITS   = 16;
   localparam int HIST_BITS    = DELIM_BITS + 8;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 400;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we    = 1'b0;
   logic [15:0] csr_wdata = '0;

   lsb_stego_extractor #(.DELIM_BITS(DELIM_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // extractor model state
   logic [15:0]          delim_reg = DELIM_RESET;
   logic [HIST_BITS-1:0] bit_hist  = '0;
   int                   bits_held = 0;
   logic                 msg_found = 1'b0;

   rsp_type results_due[$];
   int      errors       = 0;
   int      live_items   = 0;
   int      send_idle_pct = 0;
   int      stall_pct    = 0;
   int      cycle_count  = 0;
   int      hold_seq     = 0;
   int      hold_seen    = 0;
   int      hold_left    = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // consumer back-pressure; a new hold_seq starts one long hold-off
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   function automatic rsp_type make_rsp(input logic [7:0] b, input logic [3:0] nv,
                                        input logic [1:0] st, input logic lst);
      rsp_type r;
      r.msg_byte   = b;
      r.bits_valid = nv;
      r.status     = st;
      r.last       = lst;
      return r;
   endfunction

   function automatic req_type make_pixel(input logic [7:0] b, input logic [7:0] g,
                                          input logic [7:0] r, input logic eoi);
      req_type px;
      px.chan_blue    = b;
      px.chan_green   = g;
      px.chan_red     = r;
      px.end_of_image = eoi;
      return px;
   endfunction

   task automatic extract_pixel(input req_type px);
      logic [2:0]            lsbs;
      logic [7:0]            pad;
      logic [DELIM_BITS-1:0] delim_cmp;
      int                    left;
      lsbs      = {px.chan_blue[0], px.chan_green[0], px.chan_red[0]};
      delim_cmp = delim_reg;
      for (int c = 2; c >= 0; c--) begin
         if (!msg_found) begin
            bit_hist  = {bit_hist[HIST_BITS-2:0], lsbs[c]};
            bits_held = bits_held + 1;
            if (bits_held >= HIST_BITS) begin
               results_due.push_back(make_rsp(bit_hist[DELIM_BITS +: 8], 4'd8,
                                              STATUS_BYTE, 1'b0));
               bits_held = bits_held - 8;
            end
            // match only counts once a whole delimiter's worth of bits is in
            if (bits_held >= DELIM_BITS && bit_hist[DELIM_BITS-1:0] == delim_cmp) begin
               left = bits_held - DELIM_BITS;
               pad  = '0;
               if (left > 0 && left < 8) begin
                  pad = bit_hist[DELIM_BITS +: 8];
                  pad = pad << (8 - left);
               end else begin
                  left = 0;
               end
               results_due.push_back(make_rsp(pad, left[3:0], STATUS_DELIM, 1'b1));
               msg_found = 1'b1;
            end
         end
      end
      if (px.end_of_image) begin
         if (!msg_found)
            results_due.push_back(make_rsp(8'd0, 4'd0, STATUS_NOT_FOUND, 1'b1));
         bit_hist  = '0;
         bits_held = 0;
         msg_found = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input int unsigned want_v,
                              input int unsigned got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                  want_v, got_v);
         errors = errors + 1;
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time,
                     rsp_data);
            errors = errors + 1;
         end else begin
            want = results_due.pop_front();
            check_field("msg_byte", 32'(want.msg_byte), 32'(rsp_data.msg_byte));
            check_field("bits_valid", 32'(want.bits_valid), 32'(rsp_data.bits_valid));
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("last", 32'(want.last), 32'(rsp_data.last));
         end
      end
   end

   task automatic send_pixel(input req_type px);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!msg_found)
         live_items = live_items + 1;
      extract_pixel(px);
   endtask

   // packs the stream into pixel LSBs; bits past its end are random
   task automatic send_stream(input bit bits[$], input int npix);
      req_type    px;
      logic [2:0] lsb;
      for (int p = 0; p < npix; p++) begin
         for (int c = 0; c < 3; c++)
            lsb[2-c] = (3*p + c < bits.size()) ? bits[3*p + c]
                                               : 1'($urandom_range(0, 1));
         px = make_pixel(8'($urandom), 8'($urandom), 8'($urandom), p == npix - 1);
         px.chan_blue[0]  = lsb[2];
         px.chan_green[0] = lsb[1];
         px.chan_red[0]   = lsb[0];
         send_pixel(px);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_delim(input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      delim_reg = value;
   endtask

   task automatic send_random_image();
      bit          bits[$];
      int          kind;
      int          npix;
      int          flip;
      logic [15:0] pat;
      kind = $urandom_range(0, 9);
      repeat ((kind == 9) ? $urandom_range(40, 160) : $urandom_range(0, 30))
         bits.push_back(1'($urandom_range(0, 1)));
      pat = delim_reg;
      if (kind == 1) begin
         flip = $urandom_range(0, 15);
         pat[flip] = ~pat[flip];
      end
      // kind 0: pure noise, no delimiter at all
      if (kind != 0)
         for (int i = 15; i >= 0; i--) bits.push_back(pat[i]);
      repeat ($urandom_range(0, 6)) bits.push_back(1'($urandom_range(0, 1)));
      npix = (bits.size() + 2) / 3;
      if (npix == 0)
         npix = 1;
      if (kind == 2)
         npix = $urandom_range(1, npix);
      send_stream(bits, npix);
   endtask

   task automatic run_random_images(input int idle_pct, input int stall_p,
                                    input logic [15:0] pattern, input int n_items);
      int target;
      wait_drained();
      send_idle_pct = idle_pct;
      stall_pct     = stall_p;
      write_delim(pattern);
      target = live_items + n_items;
      while (live_items < target)
         send_random_image();
   endtask

   task automatic test_field_extremes();
      send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b0));
      send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_pixel(make_pixel(8'hFE, 8'h01, 8'h7F, 1'b1));
      wait_drained();
   endtask

   task automatic test_early_match();
      bit bits[$];
      // all-zero history must not match a zero delimiter before 16 bits
      write_delim(16'h0000);
      repeat (18) bits.push_back(1'b0);
      send_stream(bits, 7);
      wait_drained();
   endtask

   task automatic test_byte_with_delimiter();
      bit          bits[$];
      logic [23:0] stream;
      // 24 bits: the byte release and the delimiter end land on one pixel
      write_delim(DELIM_RESET);
      stream = {8'hC3, DELIM_RESET};
      for (int i = 23; i >= 0; i--) bits.push_back(stream[i]);
      send_stream(bits, 8);
      wait_drained();
   endtask

   task automatic test_leftover_bits();
      bit bits[$];
      write_delim(16'hFFFF);
      bits = '{1, 0, 1, 0, 0};
      repeat (16) bits.push_back(1'b1);
      send_stream(bits, 8);
      wait_drained();
   endtask

   task automatic test_no_delimiter();
      bit bits[$];
      repeat (12) bits.push_back(1'b0);
      send_stream(bits, 4);
      wait_drained();
   endtask

   task automatic test_random_no_idle();
      run_random_images(0, 0, DELIM_RESET, PHASE_ITEMS);
   endtask

   task automatic test_random_sender_idle();
      run_random_images(57, 0, 16'hFFFF, PHASE_ITEMS);
   endtask

   task automatic test_random_receiver_stall();
      run_random_images(0, 57, 16'h0000, PHASE_ITEMS);
   endtask

   task automatic test_random_both_idle();
      run_random_images(20, 20, 16'($urandom), PHASE_ITEMS);
   endtask

   task automatic test_backpressure();
      bit bits[$];
      wait_drained();
      send_idle_pct = 0;
      stall_pct     = 0;
      write_delim(DELIM_RESET);
      hold_seq <= hold_seq + 1;
      repeat (240) bits.push_back(1'($urandom_range(0, 1)));
      for (int i = 15; i >= 0; i--) bits.push_back(DELIM_RESET[i]);
      send_stream(bits, (bits.size() + 2) / 3 + 2);
      // sender waits for every outstanding transaction before going on
      wait_drained();
      stall_pct = 30;
      repeat (10) send_random_image();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_early_match();
      test_byte_with_delimiter();
      test_leftover_bits();
      test_no_delimiter();
      test_random_no_idle();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();
      test_backpressure();
      wait_drained();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
